@@ rtl/ttuv_pkg.sv @@
package ttuv_pkg;

  localparam int IndexBits = 16;
  localparam int FracBits  = 16;
  localparam int DataBits  = 32;
  localparam int ThrBits   = 32;
  localparam int FactBits  = 48;
  localparam int DeltaBits = DataBits + 1;
  localparam int DetBits   = 2 * DeltaBits + 1;
  localparam int ProdBits  = DetBits + FactBits + 1;
  localparam int NumBits   = 3 * FracBits + 1;
  localparam int DivSteps  = NumBits;

  // The factor product is built from four partial products of a split difference and factor.
  localparam int DiffLoBits = 34;
  localparam int FactLoBits = FactBits / 2;
  localparam int PartBits   = DiffLoBits + 1;
  localparam int PpBits     = PartBits + FactLoBits + 1;

  localparam logic [ThrBits-1:0]  ThrReset  = ThrBits'(512);
  localparam logic [FactBits-1:0] FactReset = FactBits'(64'd100000 << FracBits);
  localparam logic [FactBits-1:0] FactMax   = {FactBits{1'b1}};

  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegFallback  = 1'b1;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDelta = 8'b0000_0010,
    StMul   = 8'b0000_0100,
    StDet   = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StProd  = 8'b0010_0000,
    StRound = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic load_delta;
    logic load_det;
    logic div_start;
    logic div_step;
    logic load_diff;
    logic acc_step;
    logic load_tan;
    logic [1:0] mul_sel;
    logic [1:0] pp_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic use_recip;
  } dp_status_t;

endpackage

@@ rtl/ttuv_if.sv @@
interface ttuv_in_if;
  import ttuv_pkg::*;
  logic valid;
  logic ready;
  logic start_of_list;
  logic [IndexBits-1:0] vertex_index;
  logic signed [DataBits-1:0] pos_x;
  logic signed [DataBits-1:0] pos_y;
  logic signed [DataBits-1:0] pos_z;
  logic signed [DataBits-1:0] tex_u;
  logic signed [DataBits-1:0] tex_v;
  modport source (output valid, start_of_list, vertex_index, pos_x, pos_y, pos_z, tex_u,
                  tex_v, input ready);
  modport sink (input valid, start_of_list, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface

interface ttuv_out_if;
  import ttuv_pkg::*;
  logic valid;
  logic ready;
  logic [IndexBits-1:0] target_index;
  logic signed [DataBits-1:0] tan_x;
  logic signed [DataBits-1:0] tan_y;
  logic signed [DataBits-1:0] tan_z;
  logic last_of_triangle;
  modport source (output valid, target_index, tan_x, tan_y, tan_z, last_of_triangle,
                  input ready);
  modport sink (input valid, target_index, tan_x, tan_y, tan_z, last_of_triangle,
                output ready);
endinterface

interface ttuv_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ttuv_datapath.sv @@
module ttuv_datapath
  import ttuv_pkg::*;
(
  input  logic                       clk_i,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic [ThrBits-1:0]         thr_i,
  input  logic [FactBits-1:0]        fallback_i,
  input  logic signed [DataBits-1:0] p0_i [3],
  input  logic signed [DataBits-1:0] p1_i [3],
  input  logic signed [DataBits-1:0] p2_i [3],
  input  logic signed [DataBits-1:0] uv0_i [2],
  input  logic signed [DataBits-1:0] uv1_i [2],
  input  logic signed [DataBits-1:0] uv2_i [2],
  output logic signed [DataBits-1:0] tan_o [3]
);

  logic signed [DeltaBits-1:0] e1_q [3];
  logic signed [DeltaBits-1:0] e2_q [3];
  logic signed [DeltaBits-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DetBits-1:0]   det_q;
  logic signed [DetBits-1:0]   diff_q;
  logic signed [DeltaBits-1:0] ma, mb, mc, md;
  logic signed [2*DeltaBits-1:0] m0, m1;
  logic [NumBits-1:0]  quo_q;
  logic [DetBits:0]    rem_q;
  logic [DetBits:0]    rem_sh;
  logic [FactBits-1:0] fact_q;
  logic signed [PartBits-1:0] pa;
  logic signed [FactLoBits:0] pb;
  logic signed [PpBits-1:0]   pp;
  logic signed [ProdBits-1:0] term;
  logic [1:0] comp;
  logic signed [ProdBits-1:0] prod_q [3];
  logic signed [DataBits-1:0] tan_q [3];
  logic [ProdBits-1:0] half;
  logic signed [ProdBits-1:0] rnd [3];
  logic signed [DataBits-1:0] sat [3];
  logic tan_zero;
  logic use_recip;

  assign use_recip = !det_q[DetBits-1] && ({{(DetBits-ThrBits){1'b0}}, thr_i} < det_q);
  assign status_o.use_recip = use_recip;
  assign comp = cmd_i.mul_sel - 2'd1;

  always_comb begin
    ma = dv2_q; mb = e1_q[0]; mc = dv1_q; md = e2_q[0];
    case (cmd_i.mul_sel)
      2'd0: begin ma = du1_q; mb = dv2_q; mc = du2_q; md = dv1_q; end
      2'd1: begin mb = e1_q[0]; md = e2_q[0]; end
      2'd2: begin mb = e1_q[1]; md = e2_q[1]; end
      default: begin mb = e1_q[2]; md = e2_q[2]; end
    endcase
    m0 = ma * mb;
    m1 = mc * md;
  end

  assign rem_sh = {rem_q[DetBits-1:0], 1'b0};

  // One partial product of the difference and the factor per cycle.
  always_comb begin
    if (cmd_i.pp_sel[1]) begin
      pa = PartBits'($signed(diff_q[DetBits-1:DiffLoBits]));
    end else begin
      pa = $signed({1'b0, diff_q[DiffLoBits-1:0]});
    end
    if (cmd_i.pp_sel[0]) begin
      pb = $signed({1'b0, fact_q[FactBits-1:FactLoBits]});
    end else begin
      pb = $signed({1'b0, fact_q[FactLoBits-1:0]});
    end
    pp = pa * pb;
    case (cmd_i.pp_sel)
      2'd0: term = ProdBits'(pp);
      2'd1: term = ProdBits'(pp) <<< FactLoBits;
      2'd2: term = ProdBits'(pp) <<< DiffLoBits;
      default: term = ProdBits'(pp) <<< (DiffLoBits + FactLoBits);
    endcase
  end

  always_comb begin
    half = ProdBits'(1) << (2 * FracBits - 1);
    for (int c = 0; c < 3; c++) begin
      rnd[c] = (prod_q[c] + $signed(half)) >>> (2 * FracBits);
      if (rnd[c] > $signed(ProdBits'(32'h7FFF_FFFF))) begin
        sat[c] = 32'sh7FFF_FFFF;
      end else if (rnd[c] < -$signed(ProdBits'(33'h0_8000_0000))) begin
        sat[c] = 32'sh8000_0000;
      end else begin
        sat[c] = DataBits'(rnd[c]);
      end
    end
    tan_zero = (sat[0] == '0) && (sat[1] == '0) && (sat[2] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_delta) begin
      for (int c = 0; c < 3; c++) begin
        e1_q[c] <= DeltaBits'(p1_i[c]) - DeltaBits'(p0_i[c]);
        e2_q[c] <= DeltaBits'(p2_i[c]) - DeltaBits'(p0_i[c]);
      end
      du1_q <= DeltaBits'(uv1_i[0]) - DeltaBits'(uv0_i[0]);
      dv1_q <= DeltaBits'(uv1_i[1]) - DeltaBits'(uv0_i[1]);
      du2_q <= DeltaBits'(uv2_i[0]) - DeltaBits'(uv0_i[0]);
      dv2_q <= DeltaBits'(uv2_i[1]) - DeltaBits'(uv0_i[1]);
    end
    if (cmd_i.load_det) begin
      det_q <= DetBits'(m0) - DetBits'(m1);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= {1'b1, {(NumBits-1){1'b0}}};
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, det_q} && !(rem_sh == '0)) begin
        rem_q <= rem_sh - {1'b0, det_q};
        quo_q <= {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh | {{DetBits{1'b0}}, quo_q[NumBits-1]};
        quo_q <= {quo_q[NumBits-2:0], 1'b0};
      end
    end
    if (cmd_i.load_diff) begin
      diff_q <= DetBits'(m0) - DetBits'(m1);
      prod_q[comp] <= '0;
      if (!use_recip) begin
        fact_q <= fallback_i;
      end else if (quo_q > NumBits'(FactMax)) begin
        fact_q <= FactMax;
      end else begin
        fact_q <= FactBits'(quo_q);
      end
    end else if (cmd_i.acc_step) begin
      prod_q[comp] <= prod_q[comp] + term;
    end
    if (cmd_i.load_tan) begin
      tan_q[0] <= tan_zero ? (DataBits'(1) << FracBits) : sat[0];
      tan_q[1] <= sat[1];
      tan_q[2] <= sat[2];
    end
  end

  assign tan_o = tan_q;

endmodule

@@ rtl/ttuv_ctrl.sv @@
module ttuv_ctrl
  import ttuv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    step_d = step_q;
    cmd_o = '0;
    done_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StDelta;
      end
      StDelta: begin
        cmd_o.load_delta = 1'b1;
        state_d = StDet;
      end
      StDet: begin
        cmd_o.mul_sel = 2'd0;
        cmd_o.load_det = 1'b1;
        cmd_o.div_start = 1'b1;
        cnt_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (!status_i.use_recip || cnt_q == 7'(DivSteps - 1)) begin
          state_d = StMul;
          cnt_d = 7'd1;
        end
      end
      StMul: begin
        cmd_o.mul_sel = cnt_q[1:0];
        cmd_o.load_diff = 1'b1;
        step_d = '0;
        state_d = StProd;
      end
      StProd: begin
        cmd_o.mul_sel = cnt_q[1:0];
        cmd_o.pp_sel = step_q;
        cmd_o.acc_step = 1'b1;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          if (cnt_q == 7'd3) begin
            state_d = StRound;
          end else begin
            cnt_d = cnt_q + 7'd1;
            state_d = StMul;
          end
        end
      end
      StRound: begin
        cmd_o.load_tan = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/triangle_tangent_from_uv_top.sv @@
// The first two corners of a triangle are only stored. The third corner keeps the block
// busy, when the reciprocal of the UV determinant is used mostly with the bit-serial
// reciprocal (49 quotient bits, one a cycle), which stops early when the fallback factor
// is used; each tangent component then has its difference loaded and its four partial
// products summed. The three results follow, one a cycle while the receiver is ready, and
// no new corner is taken until the last of them has left.
module triangle_tangent_from_uv_top
  import ttuv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ttuv_in_if.sink    in_i,
  ttuv_out_if.source out_o,
  ttuv_cfg_if.sink   cfg_i
);

  logic [ThrBits-1:0]  thr_q;
  logic [FactBits-1:0] fb_q;
  logic [1:0] cnt_q;
  logic [IndexBits-1:0] idx_q [3];
  logic signed [DataBits-1:0] pos_q [3][3];
  logic signed [DataBits-1:0] uv_q [3][2];
  logic [1:0] emit_q;
  logic emitting_q;
  logic busy, done, start;
  logic [1:0] slot;
  dp_cmd_t cmd;
  dp_status_t status;
  logic signed [DataBits-1:0] tan [3];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = !busy && !emitting_q;
  assign slot = in_i.start_of_list ? 2'd0 : cnt_q;
  assign start = in_i.valid && in_i.ready && slot >= 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      fb_q <= FactReset;
      cnt_q <= '0;
      emit_q <= '0;
      emitting_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegThreshold: thr_q <= cfg_i.data[ThrBits-1:0];
          RegFallback: fb_q <= cfg_i.data[FactBits-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        cnt_q <= (slot >= 2'd2) ? 2'd0 : slot + 2'd1;
      end
      if (done) begin
        emitting_q <= 1'b1;
        emit_q <= '0;
      end else if (emitting_q && out_o.ready) begin
        if (emit_q == 2'd2) begin
          emitting_q <= 1'b0;
          emit_q <= '0;
        end else begin
          emit_q <= emit_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      idx_q[slot] <= in_i.vertex_index;
      pos_q[slot][0] <= in_i.pos_x;
      pos_q[slot][1] <= in_i.pos_y;
      pos_q[slot][2] <= in_i.pos_z;
      uv_q[slot][0] <= in_i.tex_u;
      uv_q[slot][1] <= in_i.tex_v;
    end
  end

  ttuv_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .status_i(status), .cmd_o(cmd),
    .busy_o(busy), .done_o(done)
  );

  ttuv_datapath u_dp (
    .clk_i, .cmd_i(cmd), .status_o(status), .thr_i(thr_q), .fallback_i(fb_q),
    .p0_i(pos_q[0]), .p1_i(pos_q[1]), .p2_i(pos_q[2]),
    .uv0_i(uv_q[0]), .uv1_i(uv_q[1]), .uv2_i(uv_q[2]), .tan_o(tan)
  );

  assign out_o.valid = emitting_q;
  assign out_o.target_index = idx_q[emit_q];
  assign out_o.tan_x = tan[0];
  assign out_o.tan_y = tan[1];
  assign out_o.tan_z = tan[2];
  assign out_o.last_of_triangle = (emit_q == 2'd2);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("input taken while busy");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting_q |-> emit_q != 2'd3) else $error("emit counter out of range");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> emitting_q) else $error("results not started");
`endif

endmodule
